FILE: sv/zigzag_matrix_scan_unit_defines.svh
// Assertion macros shared by the zigzag scan unit modules.
`ifndef ZIGZAG_MATRIX_SCAN_UNIT_DEFINES_SVH
`define ZIGZAG_MATRIX_SCAN_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ZMS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ZMS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/zms_pkg.sv
// Shared types and constants of the zigzag matrix scan unit.
package zms_pkg;

   localparam int ELEM_WIDTH = 16;
   localparam int CSR_WIDTH  = 4;

   typedef enum logic {
      WALK_IDLE,
      WALK_RUN
   } walk_state_type;

   typedef struct packed {
      logic issue;
      logic last;
   } walk_status_type;

endpackage

FILE: sv/zms_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module zms_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/zms_walker.sv
// Zigzag address sequencer: walks the anti-diagonals and issues one read a cycle.
`include "zigzag_matrix_scan_unit_defines.svh"

module zms_walker #(
   parameter int MAX_SIDE = 8,
   localparam int DEPTH  = MAX_SIDE * MAX_SIDE,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int SIDE_W = $clog2(MAX_SIDE + 1),
   localparam int RC_W   = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start_walk,
   input  logic [SIDE_W-1:0]         side,
   output logic [ADDR_W-1:0]         rd_addr,
   output zms_pkg::walk_status_type  status,
   output logic                      busy
);

   zms_pkg::walk_state_type state_ff, state_in;
   logic [RC_W-1:0]   row_ff, row_in;
   logic [RC_W-1:0]   col_ff, col_in;
   logic              up_ff, up_in;
   logic [SIDE_W-1:0] side_ff, side_in;
   logic [RC_W-1:0]   nm1;
   logic              at_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= zms_pkg::WALK_IDLE;
      end else begin
         state_ff <= state_in;
      end
      row_ff  <= row_in;
      col_ff  <= col_in;
      up_ff   <= up_in;
      side_ff <= side_in;
   end

   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      up_in    = up_ff;
      side_in  = side_ff;
      nm1      = RC_W'(side_ff - 1'b1);
      at_end   = (row_ff == nm1) && (col_ff == nm1);
      unique case (state_ff)
         zms_pkg::WALK_IDLE: begin
            if (start_walk) begin
               state_in = zms_pkg::WALK_RUN;
               row_in   = '0;
               col_in   = '0;
               up_in    = 1'b1;
               side_in  = side;
            end
         end
         zms_pkg::WALK_RUN: begin
            if (at_end) begin
               state_in = zms_pkg::WALK_IDLE;
            end else if (up_ff) begin
               // Moving up-right: turn down at the right edge, right at the top edge.
               if (col_ff == nm1) begin
                  row_in = RC_W'(row_ff + 1'b1);
                  up_in  = 1'b0;
               end else if (row_ff == '0) begin
                  col_in = RC_W'(col_ff + 1'b1);
                  up_in  = 1'b0;
               end else begin
                  row_in = RC_W'(row_ff - 1'b1);
                  col_in = RC_W'(col_ff + 1'b1);
               end
            end else begin
               // Moving down-left: turn right at the bottom edge, down at the left edge.
               if (row_ff == nm1) begin
                  col_in = RC_W'(col_ff + 1'b1);
                  up_in  = 1'b1;
               end else if (col_ff == '0) begin
                  row_in = RC_W'(row_ff + 1'b1);
                  up_in  = 1'b1;
               end else begin
                  row_in = RC_W'(row_ff + 1'b1);
                  col_in = RC_W'(col_ff - 1'b1);
               end
            end
         end
         default: begin
            state_in = zms_pkg::WALK_IDLE;
         end
      endcase
   end

   assign rd_addr = ADDR_W'(ADDR_W'(row_ff) * ADDR_W'(side_ff) + ADDR_W'(col_ff));
   assign status  = '{issue: (state_ff == zms_pkg::WALK_RUN),
                      last:  (state_ff == zms_pkg::WALK_RUN) && at_end};
   assign busy    = (state_ff == zms_pkg::WALK_RUN);

   `ZMS_ASSERT_NOW(a_walk_in_bounds, clock, reset, status.issue,
      (RC_W + 1)'(row_ff) < (RC_W + 1)'(side_ff) && (RC_W + 1)'(col_ff) < (RC_W + 1)'(side_ff),
      "zigzag walk left the matrix")
   `ZMS_ASSERT_NEXT(a_walk_starts_at_origin, clock, reset,
      start_walk && (state_ff == zms_pkg::WALK_IDLE),
      status.issue && row_ff == '0 && col_ff == '0,
      "zigzag walk did not start at the top-left element")
   `ZMS_ASSERT_NEXT(a_walk_stops_after_last, clock, reset, status.last, !status.issue,
      "zigzag walk kept issuing after the last element")

endmodule

FILE: sv/zigzag_matrix_scan_unit.sv
// Top level of the zigzag matrix scan unit: load counter, matrix RAM, zigzag walker and result strobe.
//
//  channel   direction  handshake            beat content
//  req_      in         start & !busy        req_element_value (row-major)
//  rsp_      out        rsp_valid (1 cycle)  rsp_scanned_value, rsp_last_of_matrix
//  csr_      in         csr_wr_en            csr_wr_data = matrix side
//
// Loading writes each accepted beat into the RAM; busy stays low while a matrix fills.
// The beat that completes an n by n matrix starts a scan: busy is high while the walker
// issues one RAM read per cycle, and each result strobes in the cycle after its read.
// Loading and scanning do not overlap: no beat is accepted until the scan ends.
// Reset clears the load count, sets the side to the maximum and drops any scan.
// The receiver cannot stall; results come out back to back during a scan.
`include "zigzag_matrix_scan_unit_defines.svh"

module zigzag_matrix_scan_unit #(
   parameter int MAX_SIDE   = 8,
   parameter int DATA_WIDTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [zms_pkg::ELEM_WIDTH-1:0]  req_element_value,
   output logic                            rsp_valid,
   output logic [zms_pkg::ELEM_WIDTH-1:0]  rsp_scanned_value,
   output logic                            rsp_last_of_matrix,
   input  logic                            csr_wr_en,
   input  logic [zms_pkg::CSR_WIDTH-1:0]   csr_wr_data
);

   localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int SIDE_W = $clog2(MAX_SIDE + 1);
   localparam int ElemW  = zms_pkg::ELEM_WIDTH;

   logic [SIDE_W-1:0]         side_ff, side_in;
   logic [CNT_W-1:0]          total_ff, total_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      rsp_valid_ff, rsp_last_ff;
   logic                      accept;
   logic                      matrix_full;
   logic                      walk_busy;
   logic [ADDR_W-1:0]         rd_addr;
   logic [DATA_WIDTH-1:0]     rd_data;
   zms_pkg::walk_status_type  status;

   assign accept      = start && !walk_busy;
   assign matrix_full = (CNT_W'(count_ff + 1'b1) == total_ff);

   // Side is saturated into 1..MAX_SIDE when written, so the rest of the logic never sees 0.
   always_comb begin
      side_in  = side_ff;
      total_in = total_ff;
      count_in = count_ff;
      if (csr_wr_en) begin
         priority if (csr_wr_data == '0) begin
            side_in = SIDE_W'(1);
         end else if (csr_wr_data > zms_pkg::CSR_WIDTH'(MAX_SIDE)) begin
            side_in = SIDE_W'(MAX_SIDE);
         end else begin
            side_in = SIDE_W'(csr_wr_data);
         end
         total_in = CNT_W'(side_in) * CNT_W'(side_in);
         count_in = '0;
      end else if (accept) begin
         count_in = matrix_full ? '0 : CNT_W'(count_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff      <= SIDE_W'(MAX_SIDE);
         total_ff     <= CNT_W'(DEPTH);
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         side_ff      <= side_in;
         total_ff     <= total_in;
         count_ff     <= count_in;
         rsp_valid_ff <= status.issue;
      end
      rsp_last_ff <= status.last;
   end

   zms_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_matrix_ram (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (DATA_WIDTH'(req_element_value)),
      .rd_en   (status.issue),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   zms_walker #(
      .MAX_SIDE (MAX_SIDE)
   ) u_walker (
      .clock      (clock),
      .reset      (reset),
      .start_walk (accept && matrix_full),
      .side       (side_ff),
      .rd_addr    (rd_addr),
      .status     (status),
      .busy       (walk_busy)
   );

   assign busy               = walk_busy;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_scanned_value  = ElemW'(rd_data);
   assign rsp_last_of_matrix = rsp_valid_ff && rsp_last_ff;

   `ZMS_ASSERT_NOW(a_count_clear_in_scan, clock, reset, walk_busy, count_ff == '0,
      "load count not cleared while the matrix is being scanned")
   `ZMS_ASSERT_NEXT(a_gap_after_last, clock, reset, rsp_valid_ff && rsp_last_ff, !rsp_valid_ff,
      "result beat directly followed the last beat of a matrix")
   `ZMS_ASSERT_NOW(a_count_in_range, clock, reset, 1'b1, count_ff < total_ff,
      "load count reached the matrix size")

endmodule
